// ----- rtl/sweep_scan_target_locator_core_defines.svh -----
// Assertion macros shared by the sweep scan target locator RTL.
`ifndef SWEEP_SCAN_TARGET_LOCATOR_CORE_DEFINES_SVH
`define SWEEP_SCAN_TARGET_LOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk and idle while rst_n is low.
`define SSTL_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and idle while rst_n is low.
`define SSTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sstl_pkg.sv -----
// Types, constants and a helper function shared by the target locator RTL.
`timescale 1ns / 1ps
`default_nettype none

package sstl_pkg;

    // Field widths
    localparam int SAMPLE_W  = 10;
    localparam int READ_W    = 11;
    localparam int THR_W     = 11;
    localparam int MINRUN_W  = 8;
    localparam int PULSE_W   = 11;
    localparam int ANGLE_W   = 8;
    localparam int WIDTH_W   = 7;
    localparam int IDX_W     = 8;
    localparam int CALCNT_W  = 7;
    localparam int CALSUM_W  = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 11;

    // Full servo travel in degrees
    localparam int MAX_ANGLE = 180;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN          = 1'd1;

    // Configuration reset values
    localparam logic signed [THR_W-1:0] THRESHOLD_RST = 11'sd75;
    localparam logic [MINRUN_W-1:0]     MIN_RUN_RST   = 8'd3;

    // Calibration averages this many samples per angle
    localparam logic [CALCNT_W-1:0] CAL_SAMPLES = 7'd100;

    // Divide by 100 as multiply by ceil(2^24/100), exact for sums below 2^17
    localparam logic [17:0] DIV100_MUL   = 18'd167773;
    localparam int          DIV100_SHIFT = 24;

    // Evaluation runs when the position lands on a multiple of ten
    localparam logic [3:0] EVAL_MOD_LAST = 4'd9;

    // Pulse width: 750 + 1000*angle/180 = 750 + (angle*364100) >> 16
    localparam logic [PULSE_W-1:0] PULSE_BASE  = 11'd750;
    localparam logic [26:0]        PULSE_MUL   = 27'd364100;
    localparam int                 PULSE_SHIFT = 16;

    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic               servo_write;
        logic [PULSE_W-1:0] servo_pulse_us;
        logic               target_in_view;
        logic [ANGLE_W-1:0] target_angle;
        logic [WIDTH_W-1:0] target_width;
        logic               calibration_done;
    } out_item_t;

    // Control from the sequencer into the run finder
    typedef struct packed {
        logic clear;
        logic vld;
        logic last;
    } run_ctl_t;

    // Best run found so far
    typedef struct packed {
        logic [IDX_W-1:0] best_start;
        logic [IDX_W-1:0] best_len;
    } run_res_t;

    function automatic logic [PULSE_W-1:0] pulse_for(input logic [ANGLE_W-1:0] angle);
        logic [26:0] prod;
        prod = 27'(angle) * PULSE_MUL;
        return PULSE_BASE + PULSE_W'(prod >> PULSE_SHIFT);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sweep_scan_target_locator_core.sv -----
// Sweep scan target locator: calibration averager, sweep stepper and run search.
// Flow: a plain calibration beat goes straight to the result; one that closes an angle
// average passes the divide and baseline write states; a scan beat writes its reading and
// may trigger a search that walks the reading memory one entry per cycle. Beats are taken
// one at a time, the next one in the cycle after the result loads.
// Reset: rst_n clears control and valid bits at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "sweep_scan_target_locator_core_defines.svh"

module sweep_scan_target_locator_core #(
    parameter int SWEEP_SPAN = 135
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire sstl_pkg::in_item_t                   in_item,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output sstl_pkg::out_item_t                       out_item,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [sstl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [sstl_pkg::CFG_DAT_W-1:0]       cfg_data
);

    localparam int POINTS = SWEEP_SPAN + 1;
    localparam int REST   = (sstl_pkg::MAX_ANGLE - SWEEP_SPAN) / 2;
    localparam int AW     = $clog2(POINTS);
    localparam int CW     = $clog2(POINTS + 1);
    localparam logic [sstl_pkg::PULSE_W-1:0] REST_PULSE =
        sstl_pkg::pulse_for(sstl_pkg::ANGLE_W'(REST));

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CAL_DIV  = 7'b0000010,
        S_CAL_WR   = 7'b0000100,
        S_SCAN_WR  = 7'b0001000,
        S_EVAL     = 7'b0010000,
        S_EVAL_END = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Accepted beat
    sstl_pkg::in_item_t item_reg;
    logic               accept;

    // Sweep and calibration progress
    logic [AW-1:0]                  pos_reg, pos_next;
    logic                           fwd_reg, fwd_next;
    logic [3:0]                     mod_reg, mod_next;
    logic [AW-1:0]                  cal_index_reg, cal_index_next;
    logic [sstl_pkg::CALCNT_W-1:0]  cal_count_reg, cal_count_next;
    logic [sstl_pkg::CALSUM_W-1:0]  cal_sum_reg, cal_sum_next;
    logic [sstl_pkg::SAMPLE_W-1:0]  quot_reg, quot_next;
    logic [34:0]                    div_prod;

    // Held target report
    logic                           held_vld_reg, held_vld_next;
    logic [sstl_pkg::ANGLE_W-1:0]   held_angle_reg, held_angle_next;
    logic [sstl_pkg::WIDTH_W-1:0]   held_width_reg, held_width_next;

    // Configuration
    logic signed [sstl_pkg::THR_W-1:0] thr_reg;
    logic [sstl_pkg::MINRUN_W-1:0]     min_run_reg;

    // Pending result fields and output register
    logic                           res_write_reg, res_write_next;
    logic [sstl_pkg::PULSE_W-1:0]   res_pulse_reg, res_pulse_next;
    logic                           res_done_reg, res_done_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_load;
    sstl_pkg::out_item_t            out_item_reg;

    // Baseline memory
    logic [sstl_pkg::SAMPLE_W-1:0]  base_mem [POINTS];
    logic [POINTS-1:0]              base_vld_reg;
    logic [sstl_pkg::SAMPLE_W-1:0]  base_rdata_reg;
    logic                           base_rvld_reg;
    logic                           base_wr;
    logic [sstl_pkg::SAMPLE_W-1:0]  base_val;

    // Reading memory
    logic signed [sstl_pkg::READ_W-1:0] read_mem [POINTS];
    logic [POINTS-1:0]                  read_vld_reg;
    logic signed [sstl_pkg::READ_W-1:0] read_rdata_reg;
    logic                               read_rvld_reg;
    logic                               read_wr;
    logic                               read_rd;
    logic signed [sstl_pkg::READ_W-1:0] read_diff;
    logic signed [sstl_pkg::READ_W-1:0] read_val;

    // Search walk
    logic [CW-1:0]                  addr_reg, addr_next;
    logic                           pend_reg;
    logic                           last_reg;
    sstl_pkg::run_ctl_t             run_ctl;
    sstl_pkg::run_res_t             run_res;

    // Sweep step helpers
    logic                           at_top;
    logic                           at_bot;
    logic                           edge_hit;
    logic [3:0]                     mod_step;
    logic                           eval_go;
    logic [9:0]                     centre;
    logic [9:0]                     angle_sum;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign div_prod  = 35'(cal_sum_reg) * 35'(sstl_pkg::DIV100_MUL);
    assign base_val  = base_rvld_reg ? base_rdata_reg : '0;
    assign read_val  = read_rvld_reg ? read_rdata_reg : '0;
    assign read_diff = $signed({1'b0, item_reg.sample}) - $signed({1'b0, base_val});
    assign read_rd   = (state_reg == S_EVAL) && (addr_reg != CW'(POINTS));

    // Step the sweep position, wrapping the mod-ten phase with it
    always_comb
    begin
        at_top   = (pos_reg == AW'(SWEEP_SPAN));
        at_bot   = (pos_reg == '0);
        edge_hit = fwd_reg ? at_top : at_bot;
        if (fwd_reg)
        begin
            mod_step = (mod_reg == sstl_pkg::EVAL_MOD_LAST) ? 4'd0 : (mod_reg + 4'd1);
        end
        else
        begin
            mod_step = (mod_reg == 4'd0) ? sstl_pkg::EVAL_MOD_LAST : (mod_reg - 4'd1);
        end
        eval_go = (fwd_reg || !at_bot) && (mod_step == 4'd0);
    end

    // Smoothed centre angle of the best run
    always_comb
    begin
        centre    = 10'(REST) + 10'(run_res.best_start) + 10'(run_res.best_len >> 1);
        angle_sum = 10'(held_angle_reg) + centre;
    end

    // Sequence one beat
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        fwd_next        = fwd_reg;
        mod_next        = mod_reg;
        cal_index_next  = cal_index_reg;
        cal_count_next  = cal_count_reg;
        cal_sum_next    = cal_sum_reg;
        quot_next       = quot_reg;
        held_vld_next   = held_vld_reg;
        held_angle_next = held_angle_reg;
        held_width_next = held_width_reg;
        res_write_next  = res_write_reg;
        res_pulse_next  = res_pulse_reg;
        res_done_next   = res_done_reg;
        addr_next       = addr_reg;
        base_wr         = 1'b0;
        read_wr         = 1'b0;
        out_load        = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        run_ctl.clear   = 1'b0;
        run_ctl.vld     = pend_reg;
        run_ctl.last    = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.mode)
                    begin
                        cal_sum_next   = cal_sum_reg + sstl_pkg::CALSUM_W'(in_item.sample);
                        cal_count_next = cal_count_reg + 7'd1;
                        if (cal_count_next >= sstl_pkg::CAL_SAMPLES)
                        begin
                            state_next = S_CAL_DIV;
                        end
                        else
                        begin
                            res_write_next = 1'b0;
                            res_pulse_next = '0;
                            res_done_next  = 1'b0;
                            state_next     = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN_WR;
                    end
                end
            end

            S_CAL_DIV:
            begin
                quot_next  = sstl_pkg::SAMPLE_W'(div_prod >> sstl_pkg::DIV100_SHIFT);
                state_next = S_CAL_WR;
            end

            S_CAL_WR:
            begin
                base_wr        = 1'b1;
                cal_sum_next   = '0;
                cal_count_next = '0;
                res_write_next = 1'b1;
                if (cal_index_reg == AW'(SWEEP_SPAN))
                begin
                    cal_index_next = '0;
                    res_pulse_next = REST_PULSE;
                    res_done_next  = 1'b1;
                end
                else
                begin
                    cal_index_next = cal_index_reg + AW'(1);
                    res_pulse_next = sstl_pkg::pulse_for(sstl_pkg::ANGLE_W'(REST)
                                     + sstl_pkg::ANGLE_W'(cal_index_next));
                    res_done_next  = 1'b0;
                end
                state_next = S_DONE;
            end

            S_SCAN_WR:
            begin
                read_wr       = 1'b1;
                res_done_next = 1'b0;
                if (edge_hit)
                begin
                    fwd_next       = !fwd_reg;
                    res_write_next = 1'b0;
                    res_pulse_next = '0;
                end
                else
                begin
                    pos_next       = fwd_reg ? (pos_reg + AW'(1)) : (pos_reg - AW'(1));
                    mod_next       = mod_step;
                    res_write_next = 1'b1;
                    res_pulse_next = sstl_pkg::pulse_for(sstl_pkg::ANGLE_W'(REST)
                                     + sstl_pkg::ANGLE_W'(pos_next));
                end
                if (eval_go)
                begin
                    run_ctl.clear = 1'b1;
                    addr_next     = '0;
                    state_next    = S_EVAL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_EVAL:
            begin
                if (read_rd)
                begin
                    addr_next = addr_reg + CW'(1);
                end
                if (pend_reg && last_reg)
                begin
                    state_next = S_EVAL_END;
                end
            end

            S_EVAL_END:
            begin
                if (sstl_pkg::MINRUN_W'(run_res.best_len) > min_run_reg)
                begin
                    held_vld_next   = 1'b1;
                    held_angle_next = angle_sum[8:1];
                    held_width_next = sstl_pkg::WIDTH_W'(run_res.best_len >> 1);
                end
                else
                begin
                    held_vld_next = 1'b0;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            fwd_reg        <= 1'b1;
            mod_reg        <= '0;
            cal_index_reg  <= '0;
            cal_count_reg  <= '0;
            cal_sum_reg    <= '0;
            held_vld_reg   <= 1'b0;
            held_angle_reg <= '0;
            held_width_reg <= '0;
            out_valid_reg  <= 1'b0;
            addr_reg       <= '0;
            pend_reg       <= 1'b0;
            last_reg       <= 1'b0;
            base_vld_reg   <= '0;
            read_vld_reg   <= '0;
            thr_reg        <= sstl_pkg::THRESHOLD_RST;
            min_run_reg    <= sstl_pkg::MIN_RUN_RST;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            fwd_reg        <= fwd_next;
            mod_reg        <= mod_next;
            cal_index_reg  <= cal_index_next;
            cal_count_reg  <= cal_count_next;
            cal_sum_reg    <= cal_sum_next;
            held_vld_reg   <= held_vld_next;
            held_angle_reg <= held_angle_next;
            held_width_reg <= held_width_next;
            out_valid_reg  <= out_valid_next;
            addr_reg       <= addr_next;
            pend_reg       <= read_rd;
            last_reg       <= read_rd && (addr_reg == CW'(POINTS - 1));
            if (base_wr)
            begin
                base_vld_reg[cal_index_reg] <= 1'b1;
            end
            if (read_wr)
            begin
                read_vld_reg[pos_reg] <= 1'b1;
            end
            // Take configuration beats
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sstl_pkg::CFG_DETECT_THRESHOLD: thr_reg <= $signed(cfg_data);
                    sstl_pkg::CFG_MIN_RUN:          min_run_reg <= cfg_data[7:0];
                    default:                        ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        quot_reg       <= quot_next;
        res_write_reg  <= res_write_next;
        res_pulse_reg  <= res_pulse_next;
        res_done_reg   <= res_done_next;
        base_rvld_reg  <= base_vld_reg[pos_reg];
        if (out_load)
        begin
            out_item_reg.servo_write      <= res_write_reg;
            out_item_reg.servo_pulse_us   <= res_pulse_reg;
            out_item_reg.target_in_view   <= held_vld_reg;
            out_item_reg.target_angle     <= held_angle_reg;
            out_item_reg.target_width     <= held_width_reg;
            out_item_reg.calibration_done <= res_done_reg;
        end
        if (read_rd)
        begin
            read_rvld_reg <= read_vld_reg[addr_reg[AW-1:0]];
        end
    end

    // Baseline memory: write an average, read at the sweep position
    always_ff @(posedge clk)
    begin
        if (base_wr)
        begin
            base_mem[cal_index_reg] <= quot_reg;
        end
        base_rdata_reg <= base_mem[pos_reg];
    end

    // Reading memory: write at the sweep position, read during the search walk
    always_ff @(posedge clk)
    begin
        if (read_wr)
        begin
            read_mem[pos_reg] <= read_diff;
        end
        if (read_rd)
        begin
            read_rdata_reg <= read_mem[addr_reg[AW-1:0]];
        end
    end

    sstl_run_finder u_run_finder (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (run_ctl),
        .reading   (read_val),
        .threshold (thr_reg),
        .res       (run_res)
    );

    `SSTL_ASSERT_IMPLIES(a_pulse_needs_write, out_valid_reg && !out_item_reg.servo_write, out_item_reg.servo_pulse_us == '0, "servo pulse given without servo write")
    `SSTL_ASSERT_IMPLIES(a_done_rests, out_valid_reg && out_item_reg.calibration_done, out_item_reg.servo_write && (out_item_reg.servo_pulse_us == REST_PULSE), "calibration done without rest command")
    `SSTL_ASSERT_IMPLIES(a_out_from_done, $rose(out_valid_reg), $past(state_reg == S_DONE), "output loaded outside done state")
    `SSTL_ASSERT_IMPLIES(a_run_in_bounds, state_reg == S_EVAL_END, (9'(run_res.best_start) + 9'(run_res.best_len)) <= 9'(POINTS), "best run exceeds the store")
    `SSTL_ASSERT_NEXT(a_walk_drains, (state_reg == S_EVAL) && pend_reg && last_reg, (state_reg == S_EVAL_END) && !pend_reg, "search walk did not drain on its last read")

endmodule

`default_nettype wire

// ----- rtl/sstl_run_finder.sv -----
// Streaming finder for the first longest run of readings above threshold.
`timescale 1ns / 1ps
`default_nettype none

module sstl_run_finder (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sstl_pkg::run_ctl_t                  ctl,
    input  wire logic signed [sstl_pkg::READ_W-1:0]  reading,
    input  wire logic signed [sstl_pkg::THR_W-1:0]   threshold,
    output sstl_pkg::run_res_t                       res
);

    logic [sstl_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [sstl_pkg::IDX_W-1:0] run_start_reg, run_start_next;
    logic [sstl_pkg::IDX_W-1:0] best_start_reg, best_start_next;
    logic [sstl_pkg::IDX_W-1:0] best_len_reg, best_len_next;
    logic                       hit;
    logic                       closes;
    logic [sstl_pkg::IDX_W-1:0] run_end;
    logic [sstl_pkg::IDX_W-1:0] cand_len;

    // Close the open run at a miss, or at the last point when it still holds
    always_comb
    begin
        hit      = reading > threshold;
        closes   = !hit || ctl.last;
        run_end  = hit ? (idx_reg + 8'd1) : idx_reg;
        cand_len = run_end - run_start_reg;

        idx_next        = idx_reg;
        run_start_next  = run_start_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;

        if (ctl.clear)
        begin
            idx_next        = '0;
            run_start_next  = '0;
            best_start_next = '0;
            best_len_next   = '0;
        end
        else if (ctl.vld)
        begin
            idx_next = idx_reg + 8'd1;
            if (closes && (cand_len > best_len_reg))
            begin
                best_start_next = run_start_reg;
                best_len_next   = cand_len;
            end
            if (!hit)
            begin
                run_start_next = idx_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            run_start_reg  <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
        end
        else
        begin
            idx_reg        <= idx_next;
            run_start_reg  <= run_start_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
        end
    end

    assign res.best_start = best_start_reg;
    assign res.best_len   = best_len_reg;

endmodule

`default_nettype wire
